// File: rtl/core/ccpbd_pkg.sv
// Package for the console CPU / video bus decoder.
// Command codes, video register indexes and bus window constants; no dependencies.
package ccpbd_pkg;

	typedef enum logic [3:0] {
		CMD_CPU_RD   = 4'd0,
		CMD_CPU_WR   = 4'd1,
		CMD_VID_RD   = 4'd2,
		CMD_VID_WR   = 4'd3,
		CMD_OAM_RD   = 4'd4,
		CMD_VBLANK   = 4'd5,
		CMD_OVERFLOW = 4'd6,
		CMD_ZERO_HIT = 4'd7,
		CMD_SCANLINE = 4'd8,
		CMD_PAD_L    = 4'd9,
		CMD_PAD_R    = 4'd10,
		CMD_ROM_LOAD = 4'd11
	} cmd_t;

	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_STATUS = 3'd2;
	localparam logic [2:0] REG_OAMA   = 3'd3;
	localparam logic [2:0] REG_OAMD   = 3'd4;
	localparam logic [2:0] REG_SCROLL = 3'd5;
	localparam logic [2:0] REG_ADDR   = 3'd6;
	localparam logic [2:0] REG_DATA   = 3'd7;

	localparam logic [4:0] IO_PAD_L = 5'h16;
	localparam logic [4:0] IO_PAD_R = 5'h17;

	localparam logic [7:0] STATUS_RD_MASK = 8'hd9;
	localparam logic [7:0] STATUS_KEEP    = 8'he0;
	localparam logic [7:0] VBL_CLR_MASK   = 8'h7f;
	localparam logic [7:0] FLAG_OVERFLOW  = 8'h20;
	localparam logic [7:0] FLAG_ZERO_HIT  = 8'h40;
	localparam logic [7:0] FLAG_VBLANK    = 8'h80;
	localparam logic [7:0] CTRL_INC32     = 8'h04;

	localparam logic [15:0] VID_PAL_BASE = 16'h3f00;
	localparam logic [15:0] IO_END       = 16'h4020;

endpackage

// File: rtl/core/console_cpu_ppu_bus_decoder.sv
// Console CPU / video bus decoder: one access per beat, registered result.
// The result beat is registered and valid in the cycle after input accept; one beat per cycle
// while m_tready is high, set by the single registered pass through the selected memory port and latches.
// Reset (arst_n low, async) clears registers, latches and bank count (1); memories
// come up undefined and need no clearing pass.
// Depends on ccpbd_pkg.
module console_cpu_ppu_bus_decoder
	import ccpbd_pkg::*;
#(
	parameter int PRG_BANKS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // address[15:0], data[23:16], rom_bank[27:24], zero fill
	input  logic [3:0]  s_tuser,   // command[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // read_data[7:0]
	output logic        m_tuser,   // error[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data   // prg_bank_count
);

	localparam int BANK_W = (PRG_BANKS > 1) ? $clog2(PRG_BANKS) : 1;
	localparam int ROM_W  = BANK_W + 14;

	// Output register; the input side is taken whenever the result slot is free or drains.
	logic       out_valid_q;
	logic [7:0] rd_q;
	logic       err_q;
	logic       acc;
	logic [7:0] m_tdata_byte;

	assign s_tready  = !out_valid_q || m_tready;
	assign acc       = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = m_tdata_byte;
	assign m_tuser   = err_q;
	assign cfg_ready = 1'b1;

	logic [3:0]  cmd;
	logic [15:0] a;
	logic [7:0]  d;
	logic [3:0]  bnk;
	assign cmd = s_tuser;
	assign a   = s_tdata[15:0];
	assign d   = s_tdata[23:16];
	assign bnk = s_tdata[27:24];

	// Memories (contents undefined after reset). Palette entry 0 lives in pal0_q
	// so that its mirror write never needs a second array port.
	logic [7:0] wram   [2048];
	logic [7:0] prom   [PRG_BANKS*16384];
	logic [7:0] patt   [8192];
	logic [7:0] ntab   [7936];
	logic [7:0] pal    [256];
	logic [7:0] oam    [256];
	logic [7:0] pal0_q;

	// Control state.
	logic [7:0]  vregs_q [8];
	logic [7:0]  io_q    [32];
	logic [7:0]  spr_idx_q, scx_q, scy_q, hi_q, padl_q, padr_q;
	logic        swt_q, srt_q, awc_q;
	logic [15:0] vaddr_q;
	logic [4:0]  bank_cnt_q;

	// Upper window bank.
	logic [BANK_W-1:0] up_bank;
	always_comb begin
		if (bank_cnt_q == 5'd0)
			up_bank = '0;
		else if ({27'd0, bank_cnt_q} > PRG_BANKS)
			up_bank = BANK_W'(PRG_BANKS - 1);
		else
			up_bank = BANK_W'(bank_cnt_q - 5'd1);
	end

	// Region decode.
	logic cpu_ram, cpu_vid, cpu_io, cpu_gap, cpu_lo;
	assign cpu_ram = a[15:13] == 3'b000;
	assign cpu_vid = a[15:13] == 3'b001;
	assign cpu_io  = a[15:14] == 2'b01 && a < IO_END;
	assign cpu_gap = a[15] == 1'b0 && a[14] && a >= IO_END;
	assign cpu_lo  = a[15:14] == 2'b10;

	logic [2:0] r;
	assign r = a[2:0];

	// Video register 7 target, or the direct video address.
	logic        is_r7w;
	logic [15:0] va;
	assign is_r7w = cmd == CMD_CPU_WR && cpu_vid && r == REG_DATA && vaddr_q != 16'd0;
	assign va     = is_r7w ? vaddr_q : a;

	logic v_pat, v_nt, v_pal, v_bad;
	assign v_pat = va < 16'h2000;
	assign v_nt  = !v_pat && va < VID_PAL_BASE;
	assign v_pal = va[15:8] == 8'h3f;
	assign v_bad = va[15:14] != 2'b00;

	logic vid_we;
	assign vid_we = acc && (is_r7w || cmd == CMD_VID_WR) && !v_bad;

	logic rom_ok;
	assign rom_ok = {28'd0, bnk} < PRG_BANKS && a[15:14] == 2'b00;

	logic [ROM_W-1:0] rom_ra;
	assign rom_ra = cpu_lo ? ROM_W'(a[13:0]) : {up_bank, a[13:0]};

	// Memory ports.
	logic [7:0] wram_rd_s1, prom_rd_s1, patt_rd_s1, ntab_rd_s1, pal_rd_s1, oam_rd_s1;
	always_ff @(posedge clk) begin
		if (acc && cmd == CMD_CPU_WR && cpu_ram)
			wram[a[10:0]] <= d;
		if (acc && cmd == CMD_ROM_LOAD && rom_ok)
			prom[{bnk[BANK_W-1:0], a[13:0]}] <= d;
		if (vid_we && v_pat)
			patt[va[12:0]] <= d;
		if (vid_we && v_nt)
			ntab[va[12:0]] <= d;
		if (vid_we && v_pal && va[7:0] != 8'd0)
			pal[va[7:0]] <= d;
		if (vid_we && v_pal && va[1:0] == 2'b00)
			pal0_q <= d;
		if (acc && cmd == CMD_CPU_WR && cpu_vid && r == REG_OAMD)
			oam[spr_idx_q] <= d;
	end
	always_ff @(posedge clk) begin
		wram_rd_s1 <= wram[a[10:0]];
		prom_rd_s1 <= prom[rom_ra];
		patt_rd_s1 <= patt[a[12:0]];
		ntab_rd_s1 <= ntab[a[12:0]];
		pal_rd_s1  <= (a[7:0] == 8'd0) ? pal0_q : pal[a[7:0]];
		oam_rd_s1  <= oam[a[7:0]];
	end

	// Register-side read data and mux select for the stage-1 pick.
	typedef enum logic [2:0] {
		SRC_REG, SRC_WRAM, SRC_PROM, SRC_PATT, SRC_NTAB, SRC_PAL, SRC_OAM
	} src_t;
	src_t       src_s1;
	logic [7:0] reg_rd;
	logic       err;
	src_t       src;

	logic [7:0] st_next;
	always_comb begin
		reg_rd  = 8'd0;
		err     = 1'b0;
		src     = SRC_REG;
		st_next = vregs_q[REG_STATUS];
		unique case (cmd)
			CMD_CPU_RD: begin
				if (cpu_ram) src = SRC_WRAM;
				else if (cpu_vid) begin
					if (r == REG_STATUS) begin
						st_next = vregs_q[REG_STATUS] & STATUS_RD_MASK;
						reg_rd  = st_next;
					end else if (r == REG_SCROLL)
						reg_rd = srt_q ? scx_q : scy_q;
					else
						reg_rd = vregs_q[r];
				end else if (cpu_io) begin
					if (a[4:0] == IO_PAD_L) reg_rd = {7'd0, padl_q[0]};
					else if (a[4:0] == IO_PAD_R) reg_rd = {7'd0, padr_q[0]};
					else reg_rd = io_q[a[4:0]];
				end else if (cpu_gap) err = 1'b1;
				else src = SRC_PROM;
			end
			CMD_CPU_WR: begin
				err = cpu_gap;
				// status register write goes through the same path as the event updates
				if (cpu_vid && r == REG_STATUS) st_next = d;
			end
			CMD_VID_RD: begin
				if (v_pat) src = SRC_PATT;
				else if (v_nt) src = SRC_NTAB;
				else if (v_pal) src = SRC_PAL;
				else err = 1'b1;
			end
			CMD_VID_WR: err = v_bad;
			CMD_OAM_RD: begin
				if (a[15:8] == 8'd0) src = SRC_OAM;
				else err = 1'b1;
			end
			CMD_VBLANK: st_next = (d == 8'd1) ? (vregs_q[REG_STATUS] | FLAG_VBLANK)
				: (vregs_q[REG_STATUS] & VBL_CLR_MASK);
			CMD_OVERFLOW: st_next = vregs_q[REG_STATUS] | FLAG_OVERFLOW;
			CMD_ZERO_HIT: st_next = vregs_q[REG_STATUS] | FLAG_ZERO_HIT;
			CMD_SCANLINE: st_next = (vregs_q[REG_STATUS] & STATUS_KEEP) + {1'b0, a[6:0]};
			CMD_ROM_LOAD: err = !rom_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) vregs_q[i] <= 8'd0;
			for (int i = 0; i < 32; i++) io_q[i] <= 8'd0;
			spr_idx_q <= 8'd0; scx_q <= 8'd0; scy_q <= 8'd0; hi_q <= 8'd0;
			padl_q <= 8'd0; padr_q <= 8'd0;
			swt_q <= 1'b1; srt_q <= 1'b0; awc_q <= 1'b0;
			vaddr_q <= 16'd0;
			bank_cnt_q <= 5'd1;
			out_valid_q <= 1'b0;
			err_q <= 1'b0;
			rd_q <= 8'd0;
			src_s1 <= SRC_REG;
		end else begin
			if (cfg_valid) bank_cnt_q <= cfg_data;
			if (m_tready || !out_valid_q) out_valid_q <= acc;
			if (acc) begin
				err_q  <= err;
				rd_q   <= err ? 8'd0 : reg_rd;
				src_s1 <= err ? SRC_REG : src;
				vregs_q[REG_STATUS] <= st_next;
				if (cmd == CMD_CPU_RD && cpu_vid && r == REG_STATUS) awc_q <= 1'b0;
				if (cmd == CMD_CPU_RD && cpu_vid && r == REG_SCROLL) srt_q <= !srt_q;
				if (cmd == CMD_CPU_RD && cpu_io && a[4:0] == IO_PAD_L) padl_q <= padl_q >> 1;
				if (cmd == CMD_CPU_RD && cpu_io && a[4:0] == IO_PAD_R) padr_q <= padr_q >> 1;
				if (cmd == CMD_PAD_L) padl_q <= d;
				if (cmd == CMD_PAD_R) padr_q <= d;
				if (cmd == CMD_CPU_WR && cpu_io) io_q[a[4:0]] <= d;
				if (cmd == CMD_CPU_WR && cpu_vid) begin
					if (r != REG_STATUS) vregs_q[r] <= d;
					case (r)
						REG_OAMA: spr_idx_q <= d;
						REG_OAMD: spr_idx_q <= spr_idx_q + 8'd1;
						REG_SCROLL: begin
							if (swt_q) scx_q <= d; else scy_q <= d;
							swt_q <= !swt_q;
						end
						REG_ADDR: begin
							if (!awc_q) hi_q <= d; else vaddr_q <= {hi_q, d};
							awc_q <= !awc_q;
						end
						REG_DATA: if (vaddr_q != 16'd0)
							vaddr_q <= vaddr_q + ((vregs_q[REG_CTRL] & CTRL_INC32) != 8'd0
								? 16'd32 : 16'd1);
						default: ;
					endcase
				end
			end
		end
	end

	// Result byte: memory data arrives registered, picked here.
	logic [7:0] rd_out;
	always_comb begin
		case (src_s1)
			SRC_WRAM: rd_out = wram_rd_s1;
			SRC_PROM: rd_out = prom_rd_s1;
			SRC_PATT: rd_out = patt_rd_s1;
			SRC_NTAB: rd_out = ntab_rd_s1;
			SRC_PAL:  rd_out = pal_rd_s1;
			SRC_OAM:  rd_out = oam_rd_s1;
			default:  rd_out = rd_q;
		endcase
	end

	// Memory read ports follow the input every cycle: freeze the picked byte while stalled.
	logic [7:0] hold_q;
	logic       held_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) held_q <= 1'b0;
		else held_q <= out_valid_q && !m_tready;
	end
	always_ff @(posedge clk) if (!held_q) hold_q <= rd_out;
	assign m_tdata_byte = held_q ? hold_q : rd_out;

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 8'd0) else $error("error beat has data");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable({m_tuser, m_tdata})) else $error("result changed");
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> m_tvalid) else $error("accepted beat gave no result");
`endif

endmodule
